[design/base64_stream_encoder_defines.svh]
// Assertion macros shared by the base64 encoder modules.
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

// Condition that holds at every clock edge out of reset.
`define B64SE_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Condition on one edge that forces a condition on the next edge.
`define B64SE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/b64se_pkg.sv]
// Types, constants and the base64 alphabet for the stream encoder.
package b64se_pkg;

	localparam int unsigned GQ_DEPTH_DEF = 2;

	localparam logic [5:0] SEXTET_MASK = 6'h3F;
	localparam logic [7:0] PAD_CHAR    = 8'h3D;

	typedef enum logic [1:0] {
		PH_EMPTY = 2'd0,
		PH_ONE   = 2'd1,
		PH_TWO   = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       end_of_text;
	} out_item_t;

	typedef struct packed {
		logic [23:0] triple;
		logic [1:0]  pads;
		logic        is_end;
	} group_t;

	typedef struct packed {
		logic   valid;
		group_t grp;
	} gq_head_t;

	function automatic logic [7:0] b64_char(input logic [5:0] s);
		logic [7:0] c;
		if (s < 6'd26)
			c = 8'(8'd65 + {2'b00, s});
		else if (s < 6'd52)
			c = 8'(8'd71 + {2'b00, s});
		else if (s < 6'd62)
			c = 8'({2'b00, s} - 8'd4);
		else if (s == 6'd62)
			c = 8'h2B;
		else
			c = 8'h2F;
		return c;
	endfunction

endpackage

[design/base64_stream_encoder.sv]
// Base64 stream encoder (standard alphabet, '=' padding) top level.
// Bytes enter one per cycle while full is low; the byte marked final ends the
// message and closes its group, padded with '=' as needed. Each group of three
// bytes (or the closing partial group) yields four characters, the last of a
// message flagged with end_of_text. Characters leave through a single output
// register at one per cycle while the consumer pops each one. A completed group
// is first written into the queue, and its first character is then loaded into
// the output register once that register is free. A queue of GQ_DEPTH groups
// separates intake from output; a group stays in it until its fourth character
// is loaded, and full rises, holding off every byte, while it holds that many
// groups.
module base64_stream_encoder #(
	parameter int unsigned GQ_DEPTH = b64se_pkg::GQ_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  b64se_pkg::in_item_t  push_item,
	output logic                 empty,
	input  logic                 pop,
	output b64se_pkg::out_item_t pop_item
);

	logic                gq_full, gq_push, gq_rd;
	b64se_pkg::group_t   gq_grp;
	b64se_pkg::gq_head_t gq_head;

	b64se_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.push_item (push_item),
		.gq_full   (gq_full),
		.gq_push   (gq_push),
		.gq_grp    (gq_grp)
	);

	b64se_gq #(
		.DEPTH (GQ_DEPTH)
	) u_gq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (gq_push),
		.wr_grp  (gq_grp),
		.gq_full (gq_full),
		.rd      (gq_rd),
		.head    (gq_head)
	);

	b64se_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (gq_head),
		.gq_rd    (gq_rd),
		.empty    (empty),
		.pop      (pop),
		.pop_item (pop_item)
	);

endmodule

[design/b64se_front.sv]
// Byte intake: collects bytes into 3-byte groups and issues finished groups.
`include "base64_stream_encoder_defines.svh"

module b64se_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  b64se_pkg::in_item_t push_item,
	input  logic               gq_full,
	output logic               gq_push,
	output b64se_pkg::group_t  gq_grp
);

	b64se_pkg::phase_t phase_q, phase_d;
	logic [15:0]       pend_q, pend_d;
	logic              accept;
	logic              emit;

	assign full   = gq_full;
	assign accept = push && !gq_full;

	always_comb begin
		gq_grp.is_end = push_item.final_byte;
		emit          = push_item.final_byte;
		phase_d       = phase_q;
		pend_d        = pend_q;
		unique case (phase_q)
			b64se_pkg::PH_ONE: begin
				gq_grp.triple = {pend_q[15:8], push_item.data_byte, 8'h00};
				gq_grp.pads   = 2'd1;
				phase_d       = b64se_pkg::PH_TWO;
				pend_d        = {pend_q[15:8], push_item.data_byte};
			end
			b64se_pkg::PH_TWO: begin
				gq_grp.triple = {pend_q, push_item.data_byte};
				gq_grp.pads   = 2'd0;
				emit          = 1'b1;
			end
			default: begin
				gq_grp.triple = {push_item.data_byte, 16'h0000};
				gq_grp.pads   = 2'd2;
				phase_d       = b64se_pkg::PH_ONE;
				pend_d        = {push_item.data_byte, 8'h00};
			end
		endcase
		if (emit) begin
			phase_d = b64se_pkg::PH_EMPTY;
			pend_d  = 16'h0000;
		end
	end

	assign gq_push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= b64se_pkg::PH_EMPTY;
			pend_q  <= 16'h0000;
		end else if (accept) begin
			phase_q <= phase_d;
			pend_q  <= pend_d;
		end
	end

	`B64SE_ASSERT_NEXT(a_group_restarts, gq_push, phase_q == b64se_pkg::PH_EMPTY, "group not restarted")
	`B64SE_ASSERT(a_full_group_issued, !(accept && phase_q == b64se_pkg::PH_TWO) || gq_push, "third byte lost")

endmodule

[design/b64se_gq.sv]
// Short group queue between byte intake and character output.
`include "base64_stream_encoder_defines.svh"

module b64se_gq #(
	parameter int unsigned DEPTH = b64se_pkg::GQ_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr,
	input  b64se_pkg::group_t   wr_grp,
	output logic                gq_full,
	input  logic                rd,
	output b64se_pkg::gq_head_t head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	b64se_pkg::group_t mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_wr, do_rd;

	assign gq_full    = (cnt_q == CNT_W'(DEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.grp   = mem_q[rd_ptr_q];
	assign do_wr      = wr && !gq_full;
	assign do_rd      = rd && head.valid;

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_grp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			if (do_wr && !do_rd)
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			else if (do_rd && !do_wr)
				cnt_q <= CNT_W'(cnt_q - 1'b1);
		end
	end

	`B64SE_ASSERT(a_no_overflow, !(wr && gq_full), "group pushed into full queue")

endmodule

[design/b64se_back.sv]
// Character output: turns queued groups into base64 characters, one per cycle unless waiting on pop.
`include "base64_stream_encoder_defines.svh"

module b64se_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  b64se_pkg::gq_head_t  head,
	output logic                 gq_rd,
	output logic                 empty,
	input  logic                 pop,
	output b64se_pkg::out_item_t pop_item
);

	logic                 out_valid_q;
	b64se_pkg::out_item_t out_q;
	logic [1:0]           k_q;
	logic [5:0]           sextet;
	logic                 is_pad;
	logic                 adv, load;
	b64se_pkg::out_item_t nxt;

	assign empty    = !out_valid_q;
	assign pop_item = out_q;
	assign adv      = !out_valid_q || pop;
	assign load     = adv && head.valid;
	assign gq_rd    = load && (k_q == 2'd3);

	always_comb begin
		unique case (k_q)
			2'd0:    sextet = head.grp.triple[23:18];
			2'd1:    sextet = head.grp.triple[17:12];
			2'd2:    sextet = head.grp.triple[11:6];
			default: sextet = head.grp.triple[5:0] & b64se_pkg::SEXTET_MASK;
		endcase
		is_pad          = ({1'b0, k_q} + {1'b0, head.grp.pads}) > 3'd3;
		nxt.out_char    = is_pad ? b64se_pkg::PAD_CHAR : b64se_pkg::b64_char(sextet);
		nxt.end_of_text = head.grp.is_end && (k_q == 2'd3);
	end

	always_ff @(posedge clk) begin
		if (load)
			out_q <= nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			k_q         <= 2'd0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			k_q         <= 2'(k_q + 1'b1);
		end else if (adv) begin
			out_valid_q <= 1'b0;
		end
	end

	`B64SE_ASSERT(a_group_in_flight, (k_q == 2'd0) || head.valid, "group left queue mid-output")
	`B64SE_ASSERT_NEXT(a_end_on_last, load && (k_q != 2'd3), !out_q.end_of_text, "end flag before fourth char")

endmodule

[bench/base64_stream_encoder_tb.sv]
// Testbench for base64_stream_encoder: byte-stream stimulus checked against a scoreboard model.
`timescale 1ns / 1ps

module base64_stream_encoder_tb;

	localparam int CYCLE_LIMIT  = 250000;
	localparam int RANDOM_ITEMS = 400;
	localparam logic [8*64-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	b64se_pkg::in_item_t  push_item;
	logic                 empty;
	logic                 pop;
	b64se_pkg::out_item_t pop_item;

	b64se_pkg::phase_t    enc_phase;
	logic [7:0]           held_first;
	logic [7:0]           held_second;
	b64se_pkg::out_item_t encoded_chars[$];
	int                   mismatch_count;
	int                   cycle_count;
	bit                   send_calm;
	bit                   recv_calm;

	base64_stream_encoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.push_item (push_item),
		.empty     (empty),
		.pop       (pop),
		.pop_item  (pop_item)
	);

	initial begin
		clk = 1'b0;
	end

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL base64_stream_encoder");
			$finish;
		end
	end

	function automatic int draw_gap(input bit calm);
		return calm ? 0 : int'($urandom_range(0, 16));
	endfunction

	function automatic logic [7:0] byte_for_msg();
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0)
			return 8'h00;
		else if (pick == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// four characters per group; trailing pads become '='
	task automatic queue_group(input logic [23:0] triple, input int pads, input logic is_end);
		b64se_pkg::out_item_t ch;
		logic [5:0]           sextet;
		for (int k = 0; k < 4; k++) begin
			sextet = triple[23 - 6 * k -: 6];
			ch.out_char = (k >= 4 - pads) ? b64se_pkg::PAD_CHAR :
				ALPHABET[8 * (63 - sextet) +: 8];
			ch.end_of_text = is_end && (k == 3);
			encoded_chars.push_back(ch);
		end
	endtask

	task automatic encode_byte(input b64se_pkg::in_item_t it);
		case (enc_phase)
			b64se_pkg::PH_ONE: begin
				if (it.final_byte) begin
					queue_group({held_first, it.data_byte, 8'h00}, 1, 1'b1);
					enc_phase = b64se_pkg::PH_EMPTY;
					held_first = 8'h00;
				end else begin
					held_second = it.data_byte;
					enc_phase = b64se_pkg::PH_TWO;
				end
			end
			b64se_pkg::PH_TWO: begin
				queue_group({held_first, held_second, it.data_byte}, 0, it.final_byte);
				enc_phase = b64se_pkg::PH_EMPTY;
				held_first = 8'h00;
				held_second = 8'h00;
			end
			default: begin
				if (it.final_byte) begin
					queue_group({it.data_byte, 16'h0000}, 2, 1'b1);
					enc_phase = b64se_pkg::PH_EMPTY;
				end else begin
					held_first = it.data_byte;
					enc_phase = b64se_pkg::PH_ONE;
				end
			end
		endcase
	endtask

	// called and left at a falling edge
	task automatic send_byte(input logic [7:0] data, input logic fin);
		int                  gap;
		b64se_pkg::in_item_t it;
		gap = draw_gap(send_calm);
		it.data_byte = data;
		it.final_byte = fin;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		push_item <= it;
		do @(posedge clk); while (full);
		encode_byte(it);
		@(negedge clk);
	endtask

	// up to eight bytes, first byte in the top bits
	task automatic send_message(input logic [63:0] bytes, input int len);
		for (int i = 0; i < len; i++)
			send_byte(bytes[63 - 8 * i -: 8], i == len - 1);
	endtask

	task automatic test_padding();
		send_calm = 1'b0;
		send_message({8'h00, 56'h0}, 1);
		send_message({8'hFF, 56'h0}, 1);
		send_message({16'hFF00, 48'h0}, 2);
		send_message({16'h00FF, 48'h0}, 2);
		send_message({24'hFFFFFF, 40'h0}, 3);
		send_message({24'h000000, 40'h0}, 3);
	endtask

	task automatic test_multi_group();
		send_calm = 1'b1;
		send_message({56'hFBEFBE5A55A5C3, 8'h0}, 7);
		send_message({32'h3E3F80C0, 32'h0}, 4);
		send_calm = 1'b0;
	endtask

	task automatic test_random_messages();
		int sent;
		int len;
		int pick;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0)
				send_calm = !send_calm;
			pick = $urandom_range(0, 99);
			if (pick < 70)
				len = $urandom_range(1, 6);
			else if (pick < 95)
				len = $urandom_range(7, 20);
			else
				len = $urandom_range(21, 40);
			for (int i = 0; i < len; i++)
				send_byte(byte_for_msg(), i == len - 1);
			sent += len;
		end
		send_calm = 1'b0;
	endtask

	initial begin : drain
		int                   gap;
		b64se_pkg::out_item_t want;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 49) == 0)
				recv_calm = !recv_calm;
			gap = draw_gap(recv_calm);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			if (encoded_chars.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected char: got %h eot %b", pop_item.out_char,
						pop_item.end_of_text);
			end else begin
				want = encoded_chars.pop_front();
				if (pop_item.out_char !== want.out_char ||
						pop_item.end_of_text !== want.end_of_text) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("char mismatch: exp %h eot %b, got %h eot %b",
							want.out_char, want.end_of_text,
							pop_item.out_char, pop_item.end_of_text);
				end
			end
			@(negedge clk);
		end
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		push_item = '0;
		pop = 1'b0;
		enc_phase = b64se_pkg::PH_EMPTY;
		held_first = 8'h00;
		held_second = 8'h00;
		mismatch_count = 0;
		cycle_count = 0;
		send_calm = 1'b0;
		recv_calm = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_padding();
		test_multi_group();
		test_random_messages();
		push <= 1'b0;

		while (encoded_chars.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatch_count == 0 && encoded_chars.size() == 0) begin
			$display("PASS base64_stream_encoder");
		end else begin
			$display("FAIL base64_stream_encoder");
		end
		$finish;
	end

endmodule
